/* rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and helper functions for the Euler angle to
// quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // CORDIC datapath width, Q2.30 with headroom for the range reduction.
  localparam int ANG_W = 35;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [31:0]      trig_t;
  typedef logic signed [32:0]      comp_t;

  localparam ang_t HALF_PI  = 35'sd1686629713;
  localparam ang_t PI_Q30   = 35'sd3373259426;
  localparam ang_t GAIN_INV = 35'sd652032874;

  localparam logic [31:0] NORM_MIN = 32'd10737;

  typedef struct packed {
    trig_t sin_p;
    trig_t cos_p;
    trig_t sin_y;
    trig_t cos_y;
    trig_t sin_r;
    trig_t cos_r;
  } trig_set_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  // Arctangent of 2^-i in Q2.30, rounded to nearest.
  function automatic ang_t atan_q30(input int unsigned i);
    ang_t r;
    unique case (i)
      0:       r = 35'sd843314857;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043837;
      3:       r = 35'sd133525159;
      4:       r = 35'sd67021687;
      5:       r = 35'sd33543516;
      6:       r = 35'sd16775851;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194283;
      9:       r = 35'sd2097149;
      10:      r = 35'sd1048576;
      11:      r = 35'sd524288;
      12:      r = 35'sd262144;
      13:      r = 35'sd131072;
      14:      r = 35'sd65536;
      15:      r = 35'sd32768;
      16:      r = 35'sd16384;
      17:      r = 35'sd8192;
      18:      r = 35'sd4096;
      19:      r = 35'sd2048;
      20:      r = 35'sd1024;
      21:      r = 35'sd512;
      22:      r = 35'sd256;
      23:      r = 35'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 product back to Q2.30, rounding half up.
  function automatic trig_t rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/euler_to_quaternion_core.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts pitch, yaw and roll angles to a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless the output stalls; every stage
// is a register with its own valid bit, and a stalled output only holds
// stages that are occupied.
// Reset clears all valid bits; no data register is reset and no clearing
// pass is needed.
`default_nettype none

module euler_to_quaternion_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  input  wire logic signed [15:0] in_roll_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_quat_w,
  output logic signed [15:0]      out_quat_x,
  output logic signed [15:0]      out_quat_y,
  output logic signed [15:0]      out_quat_z,
  output logic                    out_was_normalized
);

  localparam int NP = 5;

  e2q_pkg::trig_set_t trig;
  logic               cv;
  logic [NP-1:0]      v_r;
  logic [NP:0]        rdy;
  e2q_pkg::quat_t     quat;

  logic signed [63:0] pa_r, pb_r, pc_r, pd_r;
  e2q_pkg::trig_t     cr_r [2];
  e2q_pkg::trig_t     sr_r [2];
  e2q_pkg::trig_t     ra_r, rb_r, rc_r, rd_r;
  logic signed [63:0] t_r  [8];
  e2q_pkg::trig_t     u_r  [8];
  e2q_pkg::comp_t     w_r, x_r, y_r, z_r;

  e2q_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ang_p     (in_pitch_angle),
    .ang_y     (in_yaw_angle),
    .ang_r     (in_roll_angle),
    .out_valid (cv),
    .out_ready (rdy[0]),
    .trig      (trig)
  );

  genvar gk;
  generate
    for (gk = 0; gk < NP; gk++) begin : g_rdy
      assign rdy[gk] = !v_r[gk] || rdy[gk+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= cv;
      end
      for (int k = 1; k < NP; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Pitch and yaw pairs first; each pair is then scaled by roll.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pa_r     <= trig.cos_p * trig.cos_y;
      pb_r     <= trig.sin_p * trig.sin_y;
      pc_r     <= trig.sin_p * trig.cos_y;
      pd_r     <= trig.cos_p * trig.sin_y;
      cr_r[0]  <= trig.cos_r;
      sr_r[0]  <= trig.sin_r;
    end
    if (rdy[1]) begin
      ra_r    <= e2q_pkg::rnd30(pa_r);
      rb_r    <= e2q_pkg::rnd30(pb_r);
      rc_r    <= e2q_pkg::rnd30(pc_r);
      rd_r    <= e2q_pkg::rnd30(pd_r);
      cr_r[1] <= cr_r[0];
      sr_r[1] <= sr_r[0];
    end
    if (rdy[2]) begin
      t_r[0] <= ra_r * cr_r[1];
      t_r[1] <= rb_r * sr_r[1];
      t_r[2] <= rb_r * cr_r[1];
      t_r[3] <= ra_r * sr_r[1];
      t_r[4] <= rc_r * cr_r[1];
      t_r[5] <= rd_r * sr_r[1];
      t_r[6] <= rd_r * cr_r[1];
      t_r[7] <= rc_r * sr_r[1];
    end
    if (rdy[3]) begin
      for (int i = 0; i < 8; i++) begin
        u_r[i] <= e2q_pkg::rnd30(t_r[i]);
      end
    end
    if (rdy[4]) begin
      w_r <= 33'(u_r[0]) - 33'(u_r[1]);
      x_r <= 33'(u_r[2]) + 33'(u_r[3]);
      y_r <= 33'(u_r[4]) + 33'(u_r[5]);
      z_r <= 33'(u_r[6]) - 33'(u_r[7]);
    end
  end

  assign quat.w = w_r;
  assign quat.x = x_r;
  assign quat.y = y_r;
  assign quat.z = z_r;

  e2q_norm u_norm (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (v_r[NP-1]),
    .in_ready       (rdy[NP]),
    .quat           (quat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quat_w         (out_quat_w),
    .quat_x         (out_quat_x),
    .quat_y         (out_quat_y),
    .quat_z         (out_quat_z),
    .was_normalized (out_was_normalized)
  );

endmodule

`default_nettype wire

/* rtl/e2q_cordic.sv */
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC giving sine and cosine of the three half
// angles, one iteration per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] ang_p,
  input  wire logic signed [15:0] ang_y,
  input  wire logic signed [15:0] ang_r,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output e2q_pkg::trig_set_t      trig
);

  localparam int NI = e2q_pkg::CORDIC_ITERS;
  localparam int NS = NI + 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  logic signed [15:0] ang [3];
  e2q_pkg::ang_t      h   [3];
  e2q_pkg::ang_t      z0  [3];
  logic               n0  [3];

  e2q_pkg::ang_t x_r   [NI+1][3];
  e2q_pkg::ang_t y_r   [NI+1][3];
  e2q_pkg::ang_t z_r   [NI+1][3];
  logic          neg_r [NI+1][3];

  e2q_pkg::trig_t s_r [3];
  e2q_pkg::trig_t c_r [3];

  assign rdy[NS]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  genvar gk;
  generate
    for (gk = 0; gk < NS; gk++) begin : g_rdy
      assign rdy[gk] = !v_r[gk] || rdy[gk+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign ang[0] = ang_p;
  assign ang[1] = ang_y;
  assign ang[2] = ang_r;

  // Fold the half angle into [-pi/2, pi/2]; the cosine then changes sign.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      h[l] = {{(e2q_pkg::ANG_W-32){ang[l][15]}}, ang[l], 16'd0};
      if (h[l] > e2q_pkg::HALF_PI) begin
        z0[l] = e2q_pkg::PI_Q30 - h[l];
        n0[l] = 1'b1;
      end else if (h[l] < -e2q_pkg::HALF_PI) begin
        z0[l] = -e2q_pkg::PI_Q30 - h[l];
        n0[l] = 1'b1;
      end else begin
        z0[l] = h[l];
        n0[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        x_r[0][l]   <= e2q_pkg::GAIN_INV;
        y_r[0][l]   <= '0;
        z_r[0][l]   <= z0[l];
        neg_r[0][l] <= n0[l];
      end
    end
  end

  generate
    for (gk = 1; gk <= NI; gk++) begin : g_iter
      always_ff @(posedge clk) begin
        if (rdy[gk]) begin
          for (int l = 0; l < 3; l++) begin
            neg_r[gk][l] <= neg_r[gk-1][l];
            if (!z_r[gk-1][l][e2q_pkg::ANG_W-1]) begin
              x_r[gk][l] <= x_r[gk-1][l] - (y_r[gk-1][l] >>> (gk-1));
              y_r[gk][l] <= y_r[gk-1][l] + (x_r[gk-1][l] >>> (gk-1));
              z_r[gk][l] <= z_r[gk-1][l] - e2q_pkg::atan_q30(gk-1);
            end else begin
              x_r[gk][l] <= x_r[gk-1][l] + (y_r[gk-1][l] >>> (gk-1));
              y_r[gk][l] <= y_r[gk-1][l] - (x_r[gk-1][l] >>> (gk-1));
              z_r[gk][l] <= z_r[gk-1][l] + e2q_pkg::atan_q30(gk-1);
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      for (int l = 0; l < 3; l++) begin
        s_r[l] <= 32'(y_r[NI][l]);
        c_r[l] <= neg_r[NI][l] ? 32'(-x_r[NI][l]) : 32'(x_r[NI][l]);
      end
    end
  end

  assign trig.sin_p = s_r[0];
  assign trig.cos_p = c_r[0];
  assign trig.sin_y = s_r[1];
  assign trig.cos_y = c_r[1];
  assign trig.sin_r = s_r[2];
  assign trig.cos_r = c_r[2];

endmodule

`default_nettype wire

/* rtl/e2q_norm.sv */
// ----------------------------------------------------------------------------
// e2q_norm
// Pipelined Euclidean norm, bit-per-stage square root and divider, and
// output rounding and saturation to Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_norm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire e2q_pkg::quat_t     quat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      quat_w,
  output logic signed [15:0]      quat_x,
  output logic signed [15:0]      quat_y,
  output logic signed [15:0]      quat_z,
  output logic                    was_normalized
);

  localparam int RT_N  = 32;
  localparam int DV_N  = 17;
  localparam int S_SQ  = 1;
  localparam int S_ADD = 2;
  localparam int S_SUM = 3;
  localparam int S_RT  = 4;
  localparam int S_NUM = S_RT + RT_N;
  localparam int S_OVF = S_NUM + 1;
  localparam int S_DV  = S_OVF + 1;
  localparam int S_OUT = S_DV + DV_N;
  localparam int NS    = S_OUT + 1;
  localparam int ND    = S_OUT - S_NUM;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  e2q_pkg::comp_t comp_in [4];
  e2q_pkg::comp_t comp_r  [S_OUT][4];
  logic [31:0]    mag_r   [S_NUM][4];
  logic [63:0]    sq_r    [4];
  logic [63:0]    s2_r    [2];
  logic [63:0]    sum_r;
  logic [63:0]    rv_r    [RT_N];
  logic [63:0]    rr_r    [RT_N];
  logic [31:0]    den_r   [ND];
  logic           dd_r    [ND];
  logic [46:0]    num_r   [4];
  logic [46:0]    rem_r   [DV_N+1][4];
  logic [16:0]    q_r     [DV_N+1][4];
  logic           ovf_r   [DV_N+1][4];

  logic signed [15:0] res_c [4];
  logic signed [15:0] res_r [4];
  logic               wn_r;

  assign rdy[NS]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  genvar gk;
  generate
    for (gk = 0; gk < NS; gk++) begin : g_rdy
      assign rdy[gk] = !v_r[gk] || rdy[gk+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign comp_in[0] = quat.w;
  assign comp_in[1] = quat.x;
  assign comp_in[2] = quat.y;
  assign comp_in[3] = quat.z;

  // Components travel alongside the whole pipe for sign and rounding.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int c = 0; c < 4; c++) begin
        comp_r[0][c] <= comp_in[c];
        mag_r[0][c]  <= comp_in[c][32] ? 32'(-comp_in[c]) : 32'(comp_in[c]);
      end
    end
  end

  generate
    for (gk = 1; gk < S_OUT; gk++) begin : g_comp
      always_ff @(posedge clk) begin
        if (rdy[gk]) begin
          comp_r[gk] <= comp_r[gk-1];
        end
      end
    end
    for (gk = 1; gk < S_NUM; gk++) begin : g_mag
      always_ff @(posedge clk) begin
        if (rdy[gk]) begin
          mag_r[gk] <= mag_r[gk-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[S_SQ]) begin
      for (int c = 0; c < 4; c++) begin
        sq_r[c] <= mag_r[S_SQ-1][c] * mag_r[S_SQ-1][c];
      end
    end
    if (rdy[S_ADD]) begin
      s2_r[0] <= sq_r[0] + sq_r[1];
      s2_r[1] <= sq_r[2] + sq_r[3];
    end
    if (rdy[S_SUM]) begin
      sum_r <= s2_r[0] + s2_r[1];
    end
  end

  // Square root, one result bit per stage.
  generate
    for (gk = 0; gk < RT_N; gk++) begin : g_rt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2*gk);
      logic [63:0] v_in;
      logic [63:0] r_in;
      logic [63:0] trial;
      if (gk == 0) begin : g_first
        assign v_in = sum_r;
        assign r_in = '0;
      end else begin : g_next
        assign v_in = rv_r[gk-1];
        assign r_in = rr_r[gk-1];
      end
      assign trial = r_in + BIT;
      always_ff @(posedge clk) begin
        if (rdy[S_RT+gk]) begin
          if (v_in >= trial) begin
            rv_r[gk] <= v_in - trial;
            rr_r[gk] <= (r_in >> 1) + BIT;
          end else begin
            rv_r[gk] <= v_in;
            rr_r[gk] <= r_in >> 1;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[S_NUM]) begin
      den_r[0] <= rr_r[RT_N-1][31:0];
      dd_r[0]  <= rr_r[RT_N-1][31:0] > e2q_pkg::NORM_MIN;
      for (int c = 0; c < 4; c++) begin
        num_r[c] <= ({15'd0, mag_r[S_NUM-1][c]} << 14) + {16'd0, rr_r[RT_N-1][31:1]};
      end
    end
  end

  generate
    for (gk = 1; gk < ND; gk++) begin : g_den
      always_ff @(posedge clk) begin
        if (rdy[S_NUM+gk]) begin
          den_r[gk] <= den_r[gk-1];
          dd_r[gk]  <= dd_r[gk-1];
        end
      end
    end
  endgenerate

  // A quotient of 2^17 or more saturates anyway, so only 17 bits are formed.
  always_ff @(posedge clk) begin
    if (rdy[S_OVF]) begin
      for (int c = 0; c < 4; c++) begin
        ovf_r[0][c] <= {2'b00, num_r[c]} >= ({17'd0, den_r[0]} << 17);
        rem_r[0][c] <= num_r[c];
        q_r[0][c]   <= '0;
      end
    end
  end

  generate
    for (gk = 0; gk < DV_N; gk++) begin : g_dv
      logic [48:0] dsh;
      assign dsh = {17'd0, den_r[S_DV+gk-S_NUM-1]} << (DV_N-1-gk);
      always_ff @(posedge clk) begin
        if (rdy[S_DV+gk]) begin
          for (int c = 0; c < 4; c++) begin
            ovf_r[gk+1][c] <= ovf_r[gk][c];
            if ({2'b00, rem_r[gk][c]} >= dsh) begin
              rem_r[gk+1][c] <= 47'({2'b00, rem_r[gk][c]} - dsh);
              q_r[gk+1][c]   <= q_r[gk][c] | (17'd1 << (DV_N-1-gk));
            end else begin
              rem_r[gk+1][c] <= rem_r[gk][c];
              q_r[gk+1][c]   <= q_r[gk][c];
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    logic signed [33:0] rs;
    logic [16:0]        q;
    logic               big;
    for (int c = 0; c < 4; c++) begin
      rs  = (34'(comp_r[S_OUT-1][c]) + 34'sd32768) >>> 16;
      q   = q_r[DV_N][c];
      big = ovf_r[DV_N][c];
      if (dd_r[ND-1]) begin
        if (!comp_r[S_OUT-1][c][32]) begin
          res_c[c] = (big || q > 17'd32767) ? 16'sd32767 : 16'(q);
        end else begin
          res_c[c] = (big || q >= 17'd32768) ? -16'sd32768 : 16'(-q);
        end
      end else if (rs > 34'sd32767) begin
        res_c[c] = 16'sd32767;
      end else if (rs < -34'sd32768) begin
        res_c[c] = -16'sd32768;
      end else begin
        res_c[c] = rs[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      res_r <= res_c;
      wn_r  <= dd_r[ND-1];
    end
  end

  assign quat_w         = res_r[0];
  assign quat_x         = res_r[1];
  assign quat_y         = res_r[2];
  assign quat_z         = res_r[3];
  assign was_normalized = wn_r;

endmodule

`default_nettype wire
